### rtl/tsp_pkg.sv
// shared types, constants and helper functions for the tilt to servo pulse unit
`default_nettype none
package tsp_pkg;

    // converter sample width and its saturation thresholds
    localparam int TSP_SAMPLE_BITS = 12;
    localparam int TSP_FULL        = (1 << TSP_SAMPLE_BITS) - 1;
    localparam int TSP_SAT_LOW     = 10;
    localparam int TSP_SAT_HIGH    = TSP_FULL - 10;

    // long divider shape: 17 quotient bits, remainder as wide as the divisor
    // divisor holds a sample magnitude or a 9-bit tilt span, whichever is wider
    localparam int DIV_STEPS  = 17;
    localparam int DIV_DSR_W  = (TSP_SAMPLE_BITS > 9) ? TSP_SAMPLE_BITS : 9;
    localparam int DIV_DVD_W  = DIV_DSR_W + DIV_STEPS;
    localparam int DIV_SIDE_W = 12;

    // arctangent polynomial in q0.16, angles in q2.16 radians
    localparam logic signed [19:0] C3_Q16      = -20'sd3047;
    localparam logic signed [19:0] C2_Q16      = 20'sd10441;
    localparam logic signed [19:0] C1_Q16      = -20'sd21471;
    localparam logic [17:0]        HALF_PI_Q16 = 18'd102944;
    localparam logic [17:0]        PI_Q16      = 18'd205887;

    // radians to q9.8 degrees: round(r * 46080 / pi) by reciprocal
    localparam logic [15:0] DEG_Q8_SCALE = 16'd46080;
    localparam logic [16:0] DEG_ROUND    = 17'd102943;
    localparam logic [18:0] DEG_RECIP    = 19'd333772;

    // floor(p / 180) by reciprocal, exact for p below 2^23
    localparam logic [23:0] PULSE_RECIP = 24'd11930465;
    localparam logic [7:0]  ANGLE_MAX   = 8'd180;

    typedef enum logic [2:0] {
        CFG_TILT_OFFSET = 3'd0,
        CFG_TILT_MIN    = 3'd1,
        CFG_TILT_MAX    = 3'd2,
        CFG_PULSE_MIN   = 3'd3,
        CFG_PULSE_MAX   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [8:0] tilt_offset_deg;
        logic signed [8:0] tilt_min_deg;
        logic [7:0]        tilt_max_deg;
        logic [14:0]       pulse_min_us;
        logic [14:0]       pulse_max_us;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic signed [19:0] rad;
        logic              sat;
    } t_ang;

    typedef struct packed {
        logic              valid;
        logic [16:0]       dividend;
        logic [8:0]        divisor;
        logic signed [8:0] tilt;
        logic              neg;
        logic              zero;
        logic              sat;
    } t_tilt;

    typedef struct packed {
        logic              valid;
        logic signed [8:0] tilt;
        logic [7:0]        angle;
        logic [14:0]       pulse_ofs;
        logic              sat;
    } t_res;

    // product rescaled by 2^16, rounded half away from zero
    function automatic logic signed [19:0] tsp_qmul(input logic signed [39:0] prod);
        logic [39:0]        mag;
        logic [39:0]        rnd;
        logic signed [19:0] m;
        mag = prod[39] ? 40'(-prod) : 40'(prod);
        rnd = (mag + 40'd32768) >> 16;
        m   = signed'(rnd[19:0]);
        return prod[39] ? -m : m;
    endfunction

endpackage
`default_nettype wire

### rtl/tsp_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module tsp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [tsp_pkg::DIV_DVD_W-1:0]   i_dividend,
    input  logic [tsp_pkg::DIV_DSR_W-1:0]   i_divisor,
    input  logic [tsp_pkg::DIV_SIDE_W-1:0]  i_side,
    output logic                            o_valid,
    output logic [tsp_pkg::DIV_STEPS-1:0]   o_quot,
    output logic [tsp_pkg::DIV_SIDE_W-1:0]  o_side
);
    import tsp_pkg::*;

    logic                  r_v    [0:DIV_STEPS];
    logic [DIV_DSR_W-1:0]  r_rem  [0:DIV_STEPS];
    logic [DIV_DSR_W-1:0]  r_dsr  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]  r_low  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]  r_q    [0:DIV_STEPS];
    logic [DIV_SIDE_W-1:0] r_side [0:DIV_STEPS];

    // high dividend bits start the remainder, they are below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_dividend[DIV_DVD_W-1 -: DIV_DSR_W];
        r_low[0]  <= i_dividend[DIV_STEPS-1:0];
        r_dsr[0]  <= i_divisor;
        r_q[0]    <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DIV_DSR_W:0]   n_trial;
        logic [DIV_DSR_W:0]   n_diff;
        logic                 n_bit;
        logic [DIV_DSR_W-1:0] n_rem;

        always_comb begin
            n_trial = {r_rem[k], r_low[k][DIV_STEPS-1-k]};
            n_diff  = n_trial - {1'b0, r_dsr[k]};
            n_bit   = (n_trial >= {1'b0, r_dsr[k]});
            n_rem   = n_bit ? n_diff[DIV_DSR_W-1:0] : n_trial[DIV_DSR_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_rem;
            r_low[k+1]  <= r_low[k];
            r_dsr[k+1]  <= r_dsr[k];
            r_q[k+1]    <= {r_q[k][DIV_STEPS-2:0], n_bit};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_quot  = r_q[DIV_STEPS];
    assign o_side  = r_side[DIV_STEPS];

endmodule
`default_nettype wire

### rtl/tsp_atan.sv
// sample centering, octant ratio divider and polynomial arctangent
`default_nettype none
module tsp_atan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [tsp_pkg::TSP_SAMPLE_BITS-1:0] i_raw_x,
    input  logic [tsp_pkg::TSP_SAMPLE_BITS-1:0] i_raw_y,
    output tsp_pkg::t_ang                       o_ang
);
    import tsp_pkg::*;

    typedef struct packed {
        logic               valid;
        logic [16:0]        a;
        logic signed [19:0] s;
        logic               sx;
        logic               sy;
        logic               swap;
        logic               sat;
    } t_pside;

    localparam logic [TSP_SAMPLE_BITS:0] FULL_C = (TSP_SAMPLE_BITS+1)'(TSP_FULL);

    logic [TSP_SAMPLE_BITS:0]   n_dx, n_dy, n_ndx, n_ndy;
    logic [TSP_SAMPLE_BITS-1:0] n_ax, n_ay;

    logic                       r_f_valid;
    logic [TSP_SAMPLE_BITS-1:0] r_f_lo, r_f_hi;
    logic                       r_f_sx, r_f_sy, r_f_swap, r_f_sat;

    logic                  w_dv;
    logic [DIV_STEPS-1:0]  w_quot;
    logic [DIV_SIDE_W-1:0] w_side;
    logic signed [19:0]    w_a;

    t_pside             r_ps [1:5];
    logic signed [19:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [19:0] n_r0, n_r1, n_r2, n_r3, w_a5;

    // centered sample is 2*raw - full scale, odd and never zero
    always_comb begin
        n_dx  = {i_raw_x, 1'b0} - FULL_C;
        n_dy  = {i_raw_y, 1'b0} - FULL_C;
        n_ndx = -n_dx;
        n_ndy = -n_dy;
        n_ax  = n_dx[TSP_SAMPLE_BITS] ? n_ndx[TSP_SAMPLE_BITS-1:0] : n_dx[TSP_SAMPLE_BITS-1:0];
        n_ay  = n_dy[TSP_SAMPLE_BITS] ? n_ndy[TSP_SAMPLE_BITS-1:0] : n_dy[TSP_SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_sx   <= n_dx[TSP_SAMPLE_BITS];
        r_f_sy   <= n_dy[TSP_SAMPLE_BITS];
        r_f_swap <= (n_ay > n_ax);
        r_f_lo   <= (n_ay > n_ax) ? n_ax : n_ay;
        r_f_hi   <= (n_ay > n_ax) ? n_ay : n_ax;
        r_f_sat  <= (i_raw_x < TSP_SAMPLE_BITS'(TSP_SAT_LOW))
                 || (i_raw_x > TSP_SAMPLE_BITS'(TSP_SAT_HIGH))
                 || (i_raw_y < TSP_SAMPLE_BITS'(TSP_SAT_LOW))
                 || (i_raw_y > TSP_SAMPLE_BITS'(TSP_SAT_HIGH));
    end

    // octant ratio lo * 2^16 / hi in q0.16
    tsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_f_valid),
        .i_dividend ({{(DIV_DVD_W-TSP_SAMPLE_BITS-16){1'b0}}, r_f_lo, 16'd0}),
        .i_divisor  (r_f_hi),
        .i_side     ({{(DIV_SIDE_W-4){1'b0}}, r_f_sat, r_f_swap, r_f_sy, r_f_sx}),
        .o_valid    (w_dv),
        .o_quot     (w_quot),
        .o_side     (w_side)
    );

    assign w_a = signed'({3'b000, w_quot});

    // horner stages, one product each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps[1].valid <= 1'b0;
        end else begin
            r_ps[1].valid <= w_dv;
            r_ps[1].a     <= w_quot;
            r_ps[1].s     <= tsp_qmul(40'(w_a * w_a));
            r_ps[1].sx    <= w_side[0];
            r_ps[1].sy    <= w_side[1];
            r_ps[1].swap  <= w_side[2];
            r_ps[1].sat   <= w_side[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps[2].valid <= 1'b0;
            r_ps[3].valid <= 1'b0;
            r_ps[4].valid <= 1'b0;
            r_ps[5].valid <= 1'b0;
        end else begin
            r_ps[2] <= r_ps[1];
            r_ps[3] <= r_ps[2];
            r_ps[4] <= r_ps[3];
            r_ps[5] <= r_ps[4];
        end
    end

    assign w_a5 = signed'({3'b000, r_ps[4].a});

    always_ff @(posedge i_clk) begin
        r_p1 <= tsp_qmul(40'(C3_Q16 * r_ps[1].s)) + C2_Q16;
        r_p2 <= tsp_qmul(40'(r_p1 * r_ps[2].s)) + C1_Q16;
        r_p3 <= tsp_qmul(40'(r_p2 * r_ps[3].s));
        r_p4 <= tsp_qmul(40'(r_p3 * w_a5));
    end

    // quadrant fix-ups
    always_comb begin
        n_r0 = r_p4 + signed'({3'b000, r_ps[5].a});
        n_r1 = r_ps[5].swap ? signed'({2'b00, HALF_PI_Q16}) - n_r0 : n_r0;
        n_r2 = r_ps[5].sx ? signed'({2'b00, PI_Q16}) - n_r1 : n_r1;
        n_r3 = r_ps[5].sy ? -n_r2 : n_r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ang.valid <= 1'b0;
        end else begin
            o_ang.valid <= r_ps[5].valid;
            o_ang.rad   <= n_r3;
            o_ang.sat   <= r_ps[5].sat;
        end
    end

endmodule
`default_nettype wire

### rtl/tsp_deg.sv
// radians to degrees, offset, clamp and truncation to whole degrees
`default_nettype none
module tsp_deg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsp_pkg::t_ang  i_ang,
    input  tsp_pkg::t_cfg  i_cfg,
    output tsp_pkg::t_tilt o_tilt
);
    import tsp_pkg::*;

    logic [4:1] r_v;
    logic [4:1] r_neg;
    logic [4:1] r_sat;

    logic [18:0] n_mag;
    logic [33:0] r_u1, r_u2, r_u3;
    logic [52:0] n_prod;
    logic [16:0] r_qe2, r_qe3;
    logic [34:0] r_qd3;
    logic [33:0] n_rem;
    logic [16:0] n_q;
    logic signed [17:0] n_d;
    logic signed [18:0] r_d4;

    logic signed [18:0] n_d2, n_lo, n_hi, n_cl;
    logic               r_c_v, r_c_sat;
    logic signed [18:0] r_c_d;

    logic signed [18:0] n_sh;
    logic signed [8:0]  n_tilt;
    logic signed [9:0]  n_diff, n_span;
    logic signed [17:0] n_num;
    logic [17:0]        n_anum;
    logic [9:0]         n_aspan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:1], i_ang.valid};
        end
    end

    assign n_mag  = i_ang.rad[19] ? 19'(-i_ang.rad) : i_ang.rad[18:0];
    assign n_prod = 53'(r_u1) * 53'(DEG_RECIP);

    always_ff @(posedge i_clk) begin
        r_neg <= {r_neg[3:1], i_ang.rad[19]};
        r_sat <= {r_sat[3:1], i_ang.sat};
        r_u1  <= 34'(n_mag) * 34'(DEG_Q8_SCALE) + 34'(DEG_ROUND);
        r_u2  <= r_u1;
        r_qe2 <= n_prod[52:36];
        r_u3  <= r_u2;
        r_qe3 <= r_qe2;
        r_qd3 <= 35'(r_qe2) * 35'(PI_Q16);
        r_d4  <= 19'(n_d);
    end

    // reciprocal estimate is at most one low
    always_comb begin
        n_rem = r_u3 - r_qd3[33:0];
        n_q   = (n_rem >= 34'(PI_Q16)) ? r_qe3 + 17'd1 : r_qe3;
        n_d   = r_neg[3] ? -signed'({1'b0, n_q}) : signed'({1'b0, n_q});
    end

    // offset and clamp, lower bound tested first
    always_comb begin
        n_d2 = r_d4 - (19'(i_cfg.tilt_offset_deg) <<< 8);
        n_lo = 19'(i_cfg.tilt_min_deg) <<< 8;
        n_hi = signed'({3'b000, i_cfg.tilt_max_deg, 8'd0});
        n_cl = (n_d2 < n_lo) ? n_lo : (n_d2 > n_hi) ? n_hi : n_d2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_d   <= n_cl;
        r_c_sat <= r_sat[4];
    end

    // truncate toward zero, then set up the signed map division
    always_comb begin
        n_sh    = r_c_d[18] ? (r_c_d + 19'sd255) >>> 8 : r_c_d >>> 8;
        n_tilt  = n_sh[8:0];
        n_diff  = 10'(n_tilt) - 10'(i_cfg.tilt_min_deg);
        n_span  = signed'({2'b00, i_cfg.tilt_max_deg}) - 10'(i_cfg.tilt_min_deg);
        n_num   = 18'(n_diff) * 18'sd180;
        n_anum  = n_num[17] ? 18'(-n_num) : 18'(n_num);
        n_aspan = n_span[9] ? 10'(-n_span) : 10'(n_span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tilt.valid <= 1'b0;
        end else begin
            o_tilt.valid    <= r_c_v;
            o_tilt.dividend <= n_anum[16:0];
            o_tilt.divisor  <= (n_span == 10'sd0) ? 9'd1 : n_aspan[8:0];
            o_tilt.tilt     <= n_tilt;
            o_tilt.neg      <= n_num[17] ^ n_span[9];
            o_tilt.zero     <= (n_span == 10'sd0);
            o_tilt.sat      <= r_c_sat;
        end
    end

endmodule
`default_nettype wire

### rtl/tsp_map.sv
// servo angle division, clamp and pulse span scaling
`default_nettype none
module tsp_map (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsp_pkg::t_tilt i_tilt,
    input  tsp_pkg::t_cfg  i_cfg,
    output tsp_pkg::t_res  o_res
);
    import tsp_pkg::*;

    logic                  w_dv;
    logic [DIV_STEPS-1:0]  w_quot;
    logic [DIV_SIDE_W-1:0] w_side;

    logic [14:0]       n_pspan;
    logic [7:0]        n_ang;
    logic [2:1]        r_v;
    logic signed [8:0] r_tilt1, r_tilt2;
    logic [2:1]        r_sat;
    logic [7:0]        r_ang1, r_ang2;
    logic [22:0]       r_prod2;
    logic [46:0]       n_scaled;

    tsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_tilt.valid),
        .i_dividend ({{(DIV_DVD_W-17){1'b0}}, i_tilt.dividend}),
        .i_divisor  ({{(DIV_DSR_W-9){1'b0}}, i_tilt.divisor}),
        .i_side     ({i_tilt.tilt, i_tilt.neg, i_tilt.zero, i_tilt.sat}),
        .o_valid    (w_dv),
        .o_quot     (w_quot),
        .o_side     (w_side)
    );

    // negative quotient or zero span gives angle zero
    always_comb begin
        if (w_side[2] || w_side[1]) begin
            n_ang = 8'd0;
        end else if (w_quot > 17'(ANGLE_MAX)) begin
            n_ang = ANGLE_MAX;
        end else begin
            n_ang = w_quot[7:0];
        end
        n_pspan  = (i_cfg.pulse_max_us >= i_cfg.pulse_min_us)
                 ? i_cfg.pulse_max_us - i_cfg.pulse_min_us : 15'd0;
        n_scaled = 47'(r_prod2) * 47'(PULSE_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            o_res.valid <= 1'b0;
        end else begin
            r_v         <= {r_v[1], w_dv};
            o_res.valid <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tilt1         <= signed'(w_side[11:3]);
        r_sat           <= {r_sat[1], w_side[0]};
        r_ang1          <= n_ang;
        r_tilt2         <= r_tilt1;
        r_ang2          <= r_ang1;
        r_prod2         <= 23'(r_ang1) * 23'(n_pspan);
        o_res.tilt      <= r_tilt2;
        o_res.angle     <= r_ang2;
        o_res.pulse_ofs <= n_scaled[45:31];
        o_res.sat       <= r_sat[2];
    end

endmodule
`default_nettype wire

### rtl/tilt_to_servo_pulse_unit.sv
// top level of the tilt to servo pulse unit: config registers, pipeline, result register
//
// channel   direction  transfer edge           payload
// -------   ---------  ----------------------  ------------------------------------------
// sample    in         start & !busy           i_raw_x, i_raw_y
// result    out        every edge with o_done  o_tilt_deg, o_servo_angle,
//                                              o_pulse_width_us, o_sample_saturated
// config    in         i_cfg_we                i_cfg_idx, i_cfg_wdata
//
// one sample pair enters per clock; busy is always low
// o_done rises after the accepting edge, for exactly one cycle, once the sample
// has passed the two 17-step pipelined long dividers plus the
// polynomial, degree conversion and pulse scaling multiplier stages
// synchronous active-low reset clears every valid bit and loads the
// register defaults; the receiver cannot stall, so nothing ever waits
`default_nettype none
module tilt_to_servo_pulse_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tsp_pkg::TSP_SAMPLE_BITS-1:0] i_raw_x,
    input  logic [tsp_pkg::TSP_SAMPLE_BITS-1:0] i_raw_y,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [14:0]                         i_cfg_wdata,
    output logic                                o_done,
    output logic signed [8:0]                   o_tilt_deg,
    output logic [7:0]                          o_servo_angle,
    output logic [14:0]                         o_pulse_width_us,
    output logic                                o_sample_saturated
);
    import tsp_pkg::*;

    t_cfg  r_cfg;
    t_ang  w_ang;
    t_tilt w_tilt;
    t_res  w_res;

    // fully pipelined, never holds off a transfer
    assign busy = 1'b0;

    // configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_offset_deg <= 9'sd0;
            r_cfg.tilt_min_deg    <= -9'sd60;
            r_cfg.tilt_max_deg    <= 8'd60;
            r_cfg.pulse_min_us    <= 15'd500;
            r_cfg.pulse_max_us    <= 15'd2500;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TILT_OFFSET: r_cfg.tilt_offset_deg <= signed'(i_cfg_wdata[8:0]);
                CFG_TILT_MIN:    r_cfg.tilt_min_deg    <= signed'(i_cfg_wdata[8:0]);
                CFG_TILT_MAX:    r_cfg.tilt_max_deg    <= i_cfg_wdata[7:0];
                CFG_PULSE_MIN:   r_cfg.pulse_min_us    <= i_cfg_wdata;
                CFG_PULSE_MAX:   r_cfg.pulse_max_us    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // centering, octant divide and arctangent polynomial
    tsp_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_raw_x (i_raw_x),
        .i_raw_y (i_raw_y),
        .o_ang   (w_ang)
    );

    // degrees, offset, clamp, whole-degree truncation
    tsp_deg u_deg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ang   (w_ang),
        .i_cfg   (r_cfg),
        .o_tilt  (w_tilt)
    );

    // servo angle map and pulse span scaling
    tsp_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tilt  (w_tilt),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register, pulse width wraps to 15 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_tilt_deg         <= w_res.tilt;
        o_servo_angle      <= w_res.angle;
        o_pulse_width_us   <= r_cfg.pulse_min_us + w_res.pulse_ofs;
        o_sample_saturated <= w_res.sat;
    end

    // no transfer right after reset
    a_done_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // fixed-up angle stays within one half turn
    a_rad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ang.valid |-> (w_ang.rad <= 20'sd205887) && (w_ang.rad >= -20'sd205887))
        else $error("arctangent result out of range");

    // servo angle clamp
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_servo_angle <= ANGLE_MAX))
        else $error("servo angle above 180");

endmodule
`default_nettype wire

### sim/tilt_to_servo_pulse_unit_tb.sv
// self-checking testbench for the tilt to servo pulse unit
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic signed [8:0] tilt;
    logic [7:0]        angle;
    logic [14:0]       pulse;
    logic              sat;
} t_servo_result;

class servo_scoreboard;
    t_servo_result pending_results[$];
    int            mismatches;

    // settings mirrored from the register writes
    longint offset_deg = 0;
    longint min_deg    = -60;
    longint max_deg    = 60;
    longint pmin_us    = 500;
    longint pmax_us    = 2500;

    function void write_setting(tsp_pkg::t_cfg_idx idx, logic [14:0] data);
        case (idx)
            tsp_pkg::CFG_TILT_OFFSET: offset_deg = longint'($signed(data[8:0]));
            tsp_pkg::CFG_TILT_MIN:    min_deg    = longint'($signed(data[8:0]));
            tsp_pkg::CFG_TILT_MAX:    max_deg    = longint'(data[7:0]);
            tsp_pkg::CFG_PULSE_MIN:   pmin_us    = longint'(data);
            tsp_pkg::CFG_PULSE_MAX:   pmax_us    = longint'(data);
            default: ;
        endcase
    endfunction

    // round half away from zero, positive divisor
    function longint div_round(longint n, longint d);
        longint mag;
        mag = (n < 0) ? -n : n;
        mag = (mag + d / 2) / d;
        return (n < 0) ? -mag : mag;
    endfunction

    function longint mul_q16(longint a, longint b);
        return div_round(a * b, 65536);
    endfunction

    function longint atan_q16(longint y, longint x);
        longint ax, ay, lo, hi, a, s, p, r;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        lo = (ax < ay) ? ax : ay;
        hi = (ax < ay) ? ay : ax;
        a  = (lo * 65536) / hi;
        s  = mul_q16(a, a);
        p  = mul_q16(-3047, s) + 10441;
        p  = mul_q16(p, s) - 21471;
        p  = mul_q16(p, s);
        p  = mul_q16(p, a);
        r  = p + a;
        if (ay > ax) r = 102944 - r;
        if (x < 0) r = 205887 - r;
        if (y < 0) r = -r;
        return r;
    endfunction

    function void note_sample(logic [11:0] rx, logic [11:0] ry);
        t_servo_result res;
        longint cx, cy, d, lo, hi, tilt, span, ang, pspan;
        cx   = 2 * longint'(rx) - 4095;
        cy   = 2 * longint'(ry) - 4095;
        d    = div_round(atan_q16(cy, cx) * 46080, 205887) - offset_deg * 256;
        lo   = min_deg * 256;
        hi   = max_deg * 256;
        d    = (d < lo) ? lo : (d > hi) ? hi : d;
        tilt = d / 256;
        span = max_deg - min_deg;
        ang  = 0;
        if (span != 0) ang = ((tilt - min_deg) * 180) / span;
        if (ang < 0) ang = 0;
        if (ang > 180) ang = 180;
        pspan     = (pmax_us >= pmin_us) ? pmax_us - pmin_us : 0;
        res.tilt  = tilt[8:0];
        res.angle = ang[7:0];
        res.pulse = 15'(pmin_us + (ang * pspan) / 180);
        res.sat   = (rx < 10) || (rx > 4085) || (ry < 10) || (ry > 4085);
        pending_results.push_back(res);
    endfunction

    function void check_result(t_servo_result got);
        t_servo_result want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result tilt=%0d", got.tilt);
            return;
        end
        want = pending_results.pop_front();
        if (got.tilt !== want.tilt || got.angle !== want.angle ||
            got.pulse !== want.pulse || got.sat !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp tilt=%0d ang=%0d pw=%0d sat=%0b got %0d %0d %0d %0b",
                         want.tilt, want.angle, want.pulse, want.sat,
                         got.tilt, got.angle, got.pulse, got.sat);
        end
    endfunction
endclass

module tilt_to_servo_pulse_unit_tb;
    localparam int LATENCY    = 52;
    localparam int STALL_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] i_raw_x = '0;
    logic [11:0] i_raw_y = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [14:0] i_cfg_wdata = '0;
    logic        o_done;
    logic signed [8:0] o_tilt_deg;
    logic [7:0]  o_servo_angle;
    logic [14:0] o_pulse_width_us;
    logic        o_sample_saturated;

    servo_scoreboard board = new();
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    tilt_to_servo_pulse_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_raw_x(i_raw_x), .i_raw_y(i_raw_y),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_tilt_deg(o_tilt_deg), .o_servo_angle(o_servo_angle),
        .o_pulse_width_us(o_pulse_width_us), .o_sample_saturated(o_sample_saturated)
    );

    // result monitor and stall watchdog, both on the rising edge
    always @(posedge i_clk) begin
        t_servo_result got;
        if (i_rst_n && o_done) begin
            got.tilt  = o_tilt_deg;
            got.angle = o_servo_angle;
            got.pulse = o_pulse_width_us;
            got.sat   = o_sample_saturated;
            board.check_result(got);
        end
        if (!i_rst_n || o_done || (start && !busy)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return 0;
        if (pick < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // start stays high across back-to-back transfers, drops only for a gap
    task automatic send_sample(logic [11:0] rx, logic [11:0] ry, bit gaps);
        int n;
        n = gaps ? gap_length() : 0;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_raw_x <= rx;
        i_raw_y <= ry;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_sample(rx, ry);
        @(negedge i_clk);
    endtask

    // stop sending and wait for the pipeline to drain
    task automatic drain();
        start <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write enable stays high across a burst of writes
    task automatic write_reg(tsp_pkg::t_cfg_idx idx, logic [14:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        board.write_setting(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_settings(int ofs, int lo, int hi, int pmin, int pmax);
        drain();
        write_reg(tsp_pkg::CFG_TILT_OFFSET, 15'(ofs));
        write_reg(tsp_pkg::CFG_TILT_MIN, 15'(lo));
        write_reg(tsp_pkg::CFG_TILT_MAX, 15'(hi));
        write_reg(tsp_pkg::CFG_PULSE_MIN, 15'(pmin));
        write_reg(tsp_pkg::CFG_PULSE_MAX, 15'(pmax));
        i_cfg_we <= 1'b0;
    endtask

    // random pairs, biased toward the ends of the range and equal magnitudes
    task automatic random_samples(int count);
        logic [11:0] rx, ry;
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(9);
            rx  = 12'($urandom);
            ry  = 12'($urandom);
            if (sel == 0) rx = 12'($urandom_range(12));
            else if (sel == 1) ry = 12'($urandom_range(4095, 4083));
            else if (sel == 2) ry = rx;
            else if (sel == 3) ry = 12'(4095) - rx;
            send_sample(rx, ry, 1'b1);
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: corners, axes, diagonals and saturation thresholds
        send_sample(12'd0, 12'd0, 1'b0);
        send_sample(12'd4095, 12'd4095, 1'b0);
        send_sample(12'd0, 12'd4095, 1'b0);
        send_sample(12'd4095, 12'd0, 1'b0);
        send_sample(12'd2048, 12'd2047, 1'b0);
        send_sample(12'd2047, 12'd2048, 1'b0);
        send_sample(12'd4095, 12'd2048, 1'b0);
        send_sample(12'd2048, 12'd4095, 1'b0);
        send_sample(12'd0, 12'd2047, 1'b0);
        send_sample(12'd2047, 12'd0, 1'b0);
        send_sample(12'd9, 12'd10, 1'b0);
        send_sample(12'd10, 12'd4085, 1'b0);
        send_sample(12'd4086, 12'd2000, 1'b0);
        send_sample(12'd3000, 12'd3000, 1'b0);
        send_sample(12'd1000, 12'd3095, 1'b0);
        send_sample(12'hAAA, 12'h555, 1'b0);

        // widest range with offset extremes
        load_settings(180, -180, 180, 0, 20000);
        send_sample(12'd0, 12'd2047, 1'b0);
        send_sample(12'd4095, 12'd2048, 1'b0);
        // tight range with offset extreme and inverted pulse span
        load_settings(-180, -1, 1, 20000, 0);
        send_sample(12'd4095, 12'd4095, 1'b0);
        send_sample(12'd0, 12'd0, 1'b0);
        load_settings(0, -1, 1, 1234, 1234);
        send_sample(12'd2500, 12'd2100, 1'b0);

        load_settings(0, -60, 60, 500, 2500);
        random_samples(200);
        load_settings(-180, -180, 180, 0, 20000);
        random_samples(150);
        load_settings(37, -1, 1, 20000, 0);
        random_samples(150);
        load_settings(180, -180, 1, 32767, 32767);
        random_samples(100);
        for (int ph = 0; ph < 7; ph++) begin
            load_settings($urandom_range(360) - 180, -int'($urandom_range(180, 1)),
                          $urandom_range(180, 1), $urandom_range(20000),
                          $urandom_range(20000));
            random_samples(50);
        end

        drain();
        if (board.mismatches == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire

### filelist.f
rtl/tsp_pkg.sv
rtl/tsp_div.sv
rtl/tsp_atan.sv
rtl/tsp_deg.sv
rtl/tsp_map.sv
rtl/tilt_to_servo_pulse_unit.sv
sim/tilt_to_servo_pulse_unit_tb.sv
